[design/segment_register_tls_unit_macros.svh]
// Assertion macros shared by the segment register and TLS unit.
`ifndef SEGMENT_REGISTER_TLS_UNIT_MACROS_SVH
`define SEGMENT_REGISTER_TLS_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SRTU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SRTU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/srtu_pkg.sv]
// ----------------------------------------------------------------------------
// srtu_pkg
// Types and constants of the segment register and TLS unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srtu_pkg;

    typedef enum logic [3:0] {
        OP_READ      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_SET_TLS   = 4'd2,
        OP_GET_TLS   = 4'd3,
        OP_FREE_TLS  = 4'd4,
        OP_EXEC      = 4'd5,
        OP_SIGNAL    = 4'd6,
        OP_SIGRET_DS = 4'd7,
        OP_SIGRET_CS = 4'd8
    } op_t;

    localparam logic [2:0] SR_ES = 3'd0;
    localparam logic [2:0] SR_CS = 3'd1;
    localparam logic [2:0] SR_SS = 3'd2;
    localparam logic [2:0] SR_DS = 3'd3;
    localparam logic [2:0] SR_FS = 3'd4;
    localparam logic [2:0] SR_GS = 3'd5;
    localparam int         SEG_COUNT = 6;

    localparam int          ENTRY_MIN   = 12;
    localparam logic [15:0] SEL_USER_CS = 16'h0023;
    localparam logic [15:0] SEL_USER_DS = 16'h002b;
    localparam logic [15:0] SEL_MASK    = 16'hfffc;
    localparam logic [6:0]  F_EMPTY     = 7'h28;

    // Flag bit positions
    localparam int FB_32BIT   = 0;
    localparam int FB_CONT_HI = 2;   // upper bit of the contents field
    localparam int FB_RX_ONLY = 3;
    localparam int FB_NOT_PRS = 5;

    typedef struct packed {
        logic [3:0]  operation;
        logic [2:0]  segment;
        logic [15:0] selector;
        logic [15:0] stack_selector;
        logic [3:0]  tls_entry;
        logic [31:0] desc_base;
        logic [31:0] desc_limit;
        logic [6:0]  desc_flags;
    } req_t;

    typedef struct packed {
        logic [15:0] selector_out;
        logic        fault;
        logic [15:0] error_code;
        logic        status_ok;
        logic [3:0]  entry_out;
        logic [31:0] tls_base_out;
        logic [19:0] tls_limit_out;
        logic [6:0]  tls_flags_out;
        logic [31:0] fs_base_out;
        logic [31:0] gs_base_out;
    } res_t;

endpackage

`default_nettype wire

[design/srtu_core.sv]
// ----------------------------------------------------------------------------
// srtu_core
// Segment selectors, TLS table and FS/GS bases, with the operation logic
// that computes one result and the next state from one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srtu_core #(
    parameter int TLS_ENTRIES = 3
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire srtu_pkg::req_t req,
    output srtu_pkg::res_t      res
);

    localparam int SLOT_W = (TLS_ENTRIES > 1) ? $clog2(TLS_ENTRIES) : 1;
    localparam logic [12:0] IDX_LO = 13'(srtu_pkg::ENTRY_MIN);
    localparam logic [12:0] IDX_HI = 13'(srtu_pkg::ENTRY_MIN + TLS_ENTRIES);

    logic [15:0] sel_reg  [srtu_pkg::SEG_COUNT];
    logic [15:0] sel_next [srtu_pkg::SEG_COUNT];
    logic [31:0] base_reg [TLS_ENTRIES];
    logic [31:0] base_next[TLS_ENTRIES];
    logic [19:0] lim_reg  [TLS_ENTRIES];
    logic [19:0] lim_next [TLS_ENTRIES];
    logic [6:0]  flg_reg  [TLS_ENTRIES];
    logic [6:0]  flg_next [TLS_ENTRIES];
    logic [31:0] fs_base_reg, fs_base_next;
    logic [31:0] gs_base_reg, gs_base_next;

    function automatic logic slot_valid(input logic [15:0] sel);
        logic [12:0] idx;
        idx = sel[15:3];
        return !sel[2] && (idx >= IDX_LO) && (idx < IDX_HI);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [15:0] sel);
        logic [12:0] diff;
        diff = sel[15:3] - IDX_LO;
        return diff[SLOT_W-1:0];
    endfunction

    // GDT rules for loading sel into segment register sr; the TLS entry that
    // sel names (if any) carries t_flags.
    function automatic logic loadable(input logic [2:0] sr, input logic [15:0] sel,
                                      input logic t_valid, input logic [6:0] t_flags);
        logic [12:0] idx;
        logic        ok;
        idx = sel[15:3];
        if (sel[2]) begin
            ok = 1'b0;
        end else if (sr == srtu_pkg::SR_SS) begin
            if (sel[1:0] != 2'b11) begin
                ok = 1'b0;
            end else if (sel == srtu_pkg::SEL_USER_DS) begin
                ok = 1'b1;
            end else begin
                ok = t_valid && (t_flags != 7'd0) && !t_flags[srtu_pkg::FB_RX_ONLY];
            end
        end else if (idx == 13'd0 || idx == 13'd4 || idx == 13'd5 || idx == 13'd6 ||
                     idx == 13'd15) begin
            ok = 1'b1;
        end else begin
            ok = t_valid && (t_flags != 7'd0);
        end
        return ok;
    endfunction

    logic [15:0]       rd_sel;
    logic              rd_valid;
    logic [SLOT_W-1:0] rd_slot;
    logic [31:0]       rd_base;
    logic [19:0]       rd_lim;
    logic [6:0]        rd_flg;
    logic              ent_ok;
    logic [3:0]        ent_diff;
    logic [SLOT_W-1:0] ent_slot;
    logic [15:0]       tsel;
    logic [15:0]       s7;
    logic [15:0]       cs8;
    logic [15:0]       ss8;
    logic              clr;
    logic              set_ok;
    logic [31:0]       new_base;
    logic [19:0]       new_lim;
    logic [6:0]        new_flg;
    logic              found;
    logic              seg_ok;

    always_comb begin
        ent_ok   = (req.tls_entry >= 4'(srtu_pkg::ENTRY_MIN)) &&
                   (req.tls_entry < 4'(srtu_pkg::ENTRY_MIN + TLS_ENTRIES));
        ent_diff = req.tls_entry - 4'(srtu_pkg::ENTRY_MIN);
        ent_slot = ent_diff[SLOT_W-1:0];
        tsel     = {9'd0, req.tls_entry, 3'b011};
        s7       = req.selector | 16'h0003;
        cs8      = req.selector | 16'h0003;
        ss8      = req.stack_selector | 16'h0003;
        seg_ok   = req.segment < 3'(srtu_pkg::SEG_COUNT);

        // One table read port: the entry the operation looks at
        case (req.operation)
            srtu_pkg::OP_SET_TLS, srtu_pkg::OP_GET_TLS: rd_sel = tsel;
            srtu_pkg::OP_SIGRET_CS:                     rd_sel = ss8;
            default:                                    rd_sel = req.selector;
        endcase
        rd_valid = (req.operation == srtu_pkg::OP_SET_TLS ||
                    req.operation == srtu_pkg::OP_GET_TLS) ? ent_ok : slot_valid(rd_sel);
        rd_slot  = (req.operation == srtu_pkg::OP_SET_TLS ||
                    req.operation == srtu_pkg::OP_GET_TLS) ? ent_slot : slot_of(rd_sel);
        rd_base  = rd_valid ? base_reg[rd_slot] : 32'd0;
        rd_lim   = rd_valid ? lim_reg[rd_slot]  : 20'd0;
        rd_flg   = rd_valid ? flg_reg[rd_slot]  : 7'd0;

        clr = (req.desc_base == 32'd0) && (req.desc_limit == 32'd0) &&
              (req.desc_flags == 7'd0 || req.desc_flags == srtu_pkg::F_EMPTY);
        set_ok = clr || (req.desc_flags[srtu_pkg::FB_32BIT] &&
                         !req.desc_flags[srtu_pkg::FB_CONT_HI] &&
                         !req.desc_flags[srtu_pkg::FB_NOT_PRS]);
        new_base = clr ? 32'd0 : req.desc_base;
        new_lim  = clr ? 20'd0 : req.desc_limit[19:0];
        new_flg  = clr ? 7'd0  : req.desc_flags;

        for (int i = 0; i < srtu_pkg::SEG_COUNT; i++) sel_next[i] = sel_reg[i];
        for (int i = 0; i < TLS_ENTRIES; i++) begin
            base_next[i] = base_reg[i];
            lim_next[i]  = lim_reg[i];
            flg_next[i]  = flg_reg[i];
        end
        fs_base_next = fs_base_reg;
        gs_base_next = gs_base_reg;
        found        = 1'b0;

        res = '0;

        case (req.operation)
            srtu_pkg::OP_READ: begin
                if (req.segment == srtu_pkg::SR_CS) begin
                    res.selector_out = srtu_pkg::SEL_USER_CS;
                end else if (seg_ok) begin
                    res.selector_out = sel_reg[req.segment];
                end
            end
            srtu_pkg::OP_LOAD: begin
                if (seg_ok) begin
                    if (loadable(req.segment, req.selector, rd_valid, rd_flg)) begin
                        sel_next[req.segment] = req.selector;
                        if (req.segment == srtu_pkg::SR_FS) fs_base_next = rd_base;
                        if (req.segment == srtu_pkg::SR_GS) gs_base_next = rd_base;
                    end else begin
                        res.fault      = 1'b1;
                        res.error_code = req.selector & srtu_pkg::SEL_MASK;
                    end
                end
            end
            srtu_pkg::OP_SET_TLS: begin
                if (ent_ok && set_ok) begin
                    base_next[ent_slot] = new_base;
                    lim_next[ent_slot]  = new_lim;
                    flg_next[ent_slot]  = new_flg;
                    // Reload ES, DS, FS and GS that hold this entry's selector
                    if (sel_reg[srtu_pkg::SR_ES] == tsel) begin
                        sel_next[srtu_pkg::SR_ES] =
                            loadable(srtu_pkg::SR_ES, tsel, 1'b1, new_flg) ? tsel : 16'd0;
                    end
                    if (sel_reg[srtu_pkg::SR_DS] == tsel) begin
                        sel_next[srtu_pkg::SR_DS] =
                            loadable(srtu_pkg::SR_DS, tsel, 1'b1, new_flg) ? tsel : 16'd0;
                    end
                    if (sel_reg[srtu_pkg::SR_FS] == tsel) begin
                        if (loadable(srtu_pkg::SR_FS, tsel, 1'b1, new_flg)) begin
                            sel_next[srtu_pkg::SR_FS] = tsel;
                            fs_base_next = new_base;
                        end else begin
                            sel_next[srtu_pkg::SR_FS] = 16'd0;
                            fs_base_next = 32'd0;
                        end
                    end
                    if (sel_reg[srtu_pkg::SR_GS] == tsel) begin
                        if (loadable(srtu_pkg::SR_GS, tsel, 1'b1, new_flg)) begin
                            sel_next[srtu_pkg::SR_GS] = tsel;
                            gs_base_next = new_base;
                        end else begin
                            sel_next[srtu_pkg::SR_GS] = 16'd0;
                            gs_base_next = 32'd0;
                        end
                    end
                    res.status_ok = 1'b1;
                end
            end
            srtu_pkg::OP_GET_TLS: begin
                if (ent_ok) begin
                    if (rd_flg == 7'd0) begin
                        res.tls_flags_out = srtu_pkg::F_EMPTY;
                    end else begin
                        res.tls_base_out  = rd_base;
                        res.tls_limit_out = rd_lim;
                        res.tls_flags_out = rd_flg;
                    end
                end
            end
            srtu_pkg::OP_FREE_TLS: begin
                for (int i = 0; i < TLS_ENTRIES; i++) begin
                    if (!found && flg_reg[i] == 7'd0) begin
                        found         = 1'b1;
                        res.status_ok = 1'b1;
                        res.entry_out = 4'(srtu_pkg::ENTRY_MIN + i);
                    end
                end
            end
            srtu_pkg::OP_EXEC: begin
                for (int i = 0; i < srtu_pkg::SEG_COUNT; i++) sel_next[i] = 16'd0;
                sel_next[srtu_pkg::SR_ES] = srtu_pkg::SEL_USER_DS;
                sel_next[srtu_pkg::SR_SS] = srtu_pkg::SEL_USER_DS;
                sel_next[srtu_pkg::SR_DS] = srtu_pkg::SEL_USER_DS;
                for (int i = 0; i < TLS_ENTRIES; i++) begin
                    base_next[i] = 32'd0;
                    lim_next[i]  = 20'd0;
                    flg_next[i]  = 7'd0;
                end
                fs_base_next = 32'd0;
                gs_base_next = 32'd0;
            end
            srtu_pkg::OP_SIGNAL: begin
                sel_next[srtu_pkg::SR_ES] = srtu_pkg::SEL_USER_DS;
                sel_next[srtu_pkg::SR_SS] = srtu_pkg::SEL_USER_DS;
                sel_next[srtu_pkg::SR_DS] = srtu_pkg::SEL_USER_DS;
            end
            srtu_pkg::OP_SIGRET_DS: begin
                if (seg_ok) begin
                    // Null or unloadable frame selector loads as null
                    if (s7[15:3] != 13'd0 && loadable(req.segment, s7, rd_valid, rd_flg)) begin
                        sel_next[req.segment] = s7;
                        if (req.segment == srtu_pkg::SR_FS) fs_base_next = rd_base;
                        if (req.segment == srtu_pkg::SR_GS) gs_base_next = rd_base;
                    end else begin
                        sel_next[req.segment] = 16'd0;
                        if (req.segment == srtu_pkg::SR_FS) fs_base_next = 32'd0;
                        if (req.segment == srtu_pkg::SR_GS) gs_base_next = 32'd0;
                    end
                end
            end
            srtu_pkg::OP_SIGRET_CS: begin
                if (cs8 == srtu_pkg::SEL_USER_CS &&
                    loadable(srtu_pkg::SR_SS, ss8, rd_valid, rd_flg)) begin
                    sel_next[srtu_pkg::SR_SS] = ss8;
                end else begin
                    res.fault = 1'b1;
                    if (ss8[2]) begin
                        res.error_code = 16'd0;
                    end else if (cs8 == srtu_pkg::SEL_USER_CS) begin
                        res.error_code = ss8 & srtu_pkg::SEL_MASK;
                    end else begin
                        res.error_code = cs8 & srtu_pkg::SEL_MASK;
                    end
                end
            end
            default: begin
            end
        endcase

        res.fs_base_out = fs_base_next;
        res.gs_base_out = gs_base_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < srtu_pkg::SEG_COUNT; i++) begin
                sel_reg[i] <= (i == int'(srtu_pkg::SR_ES) || i == int'(srtu_pkg::SR_SS) ||
                               i == int'(srtu_pkg::SR_DS)) ? srtu_pkg::SEL_USER_DS : 16'd0;
            end
            for (int i = 0; i < TLS_ENTRIES; i++) begin
                base_reg[i] <= 32'd0;
                lim_reg[i]  <= 20'd0;
                flg_reg[i]  <= 7'd0;
            end
            fs_base_reg <= 32'd0;
            gs_base_reg <= 32'd0;
        end else if (advance) begin
            for (int i = 0; i < srtu_pkg::SEG_COUNT; i++) sel_reg[i] <= sel_next[i];
            for (int i = 0; i < TLS_ENTRIES; i++) begin
                base_reg[i] <= base_next[i];
                lim_reg[i]  <= lim_next[i];
                flg_reg[i]  <= flg_next[i];
            end
            fs_base_reg <= fs_base_next;
            gs_base_reg <= gs_base_next;
        end
    end

endmodule

`default_nettype wire

[design/segment_register_tls_unit.sv]
// ----------------------------------------------------------------------------
// segment_register_tls_unit
// Segment selectors, TLS descriptors and FS/GS bases of a 32-bit task.
// ----------------------------------------------------------------------------
// The unit takes one operation per cycle unless stalled and returns one result
// for each. A transfer lands in the input register; when the output register
// is free or draining, the operation executes against the selector file and
// TLS table and its result enters the output register, from which it is
// offered on m_valid; the sustained rate is one item
// per cycle while m_ready stays high. The input stalls only when both
// registers hold an item and m_ready is low. The state update and the result
// of an operation are made in the same cycle, so the following operation
// always sees the updated selectors and table.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_register_tls_unit_macros.svh"

module segment_register_tls_unit #(
    parameter int TLS_ENTRIES = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_operation,
    input  wire logic [2:0]  s_segment,
    input  wire logic [15:0] s_selector,
    input  wire logic [15:0] s_stack_selector,
    input  wire logic [3:0]  s_tls_entry,
    input  wire logic [31:0] s_desc_base,
    input  wire logic [31:0] s_desc_limit,
    input  wire logic [6:0]  s_desc_flags,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_selector_out,
    output logic             m_fault,
    output logic [15:0]      m_error_code,
    output logic             m_status_ok,
    output logic [3:0]       m_entry_out,
    output logic [31:0]      m_tls_base_out,
    output logic [19:0]      m_tls_limit_out,
    output logic [6:0]       m_tls_flags_out,
    output logic [31:0]      m_fs_base_out,
    output logic [31:0]      m_gs_base_out
);

    srtu_pkg::req_t req_reg;
    srtu_pkg::res_t res_reg;
    srtu_pkg::res_t res_next;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic           advance;

    // Execute when the output register is free or draining this cycle
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.operation      <= s_operation;
            req_reg.segment        <= s_segment;
            req_reg.selector       <= s_selector;
            req_reg.stack_selector <= s_stack_selector;
            req_reg.tls_entry      <= s_tls_entry;
            req_reg.desc_base      <= s_desc_base;
            req_reg.desc_limit     <= s_desc_limit;
            req_reg.desc_flags     <= s_desc_flags;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    srtu_core #(
        .TLS_ENTRIES (TLS_ENTRIES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req     (req_reg),
        .res     (res_next)
    );

    assign m_valid         = out_valid_reg;
    assign m_selector_out  = res_reg.selector_out;
    assign m_fault         = res_reg.fault;
    assign m_error_code    = res_reg.error_code;
    assign m_status_ok     = res_reg.status_ok;
    assign m_entry_out     = res_reg.entry_out;
    assign m_tls_base_out  = res_reg.tls_base_out;
    assign m_tls_limit_out = res_reg.tls_limit_out;
    assign m_tls_flags_out = res_reg.tls_flags_out;
    assign m_fs_base_out   = res_reg.fs_base_out;
    assign m_gs_base_out   = res_reg.gs_base_out;

    `SRTU_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready)
    `SRTU_ASSERT_NEXT(a_exec_fills_output, aclk, aresetn, advance, out_valid_reg)
    `SRTU_ASSERT_NOW(a_no_fault_no_code, aclk, aresetn, out_valid_reg && !res_reg.fault,
        res_reg.error_code == 16'd0)
    `SRTU_ASSERT_NOW(a_entry_has_status, aclk, aresetn,
        out_valid_reg && res_reg.entry_out != 4'd0, res_reg.status_ok)

endmodule

`default_nettype wire

[verif/segment_register_tls_unit_tb.sv]
// ----------------------------------------------------------------------------
// segment_register_tls_unit_tb
// Self-checking bench for the segment register and TLS unit: directed and
// random operations are driven over valid/ready, and a predictor of the
// selector file, TLS table and FS/GS bases checks every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_register_tls_unit_tb;
    import srtu_pkg::*;

    localparam int TLS_ENTRIES = 3;

    // GDT indices with fixed descriptors
    localparam int GDT_NULL    = 0;
    localparam int GDT_USER_CS = 4;
    localparam int GDT_USER_DS = 5;
    localparam int GDT_CODE64  = 6;
    localparam int GDT_RO_DATA = 15;

    localparam logic [3:0] OP_UNUSED = 4'd15;
    localparam logic [6:0] F_GOOD    = 7'h5b;

    logic aclk;
    logic aresetn;

    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  in_flight = '0;
    logic  m_ready = 1'b0;

    logic        m_valid;
    logic [15:0] m_selector_out;
    logic        m_fault;
    logic [15:0] m_error_code;
    logic        m_status_ok;
    logic [3:0]  m_entry_out;
    logic [31:0] m_tls_base_out;
    logic [19:0] m_tls_limit_out;
    logic [6:0]  m_tls_flags_out;
    logic [31:0] m_fs_base_out;
    logic [31:0] m_gs_base_out;

    segment_register_tls_unit #(.TLS_ENTRIES(TLS_ENTRIES)) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (in_flight.operation),
        .s_segment       (in_flight.segment),
        .s_selector      (in_flight.selector),
        .s_stack_selector(in_flight.stack_selector),
        .s_tls_entry     (in_flight.tls_entry),
        .s_desc_base     (in_flight.desc_base),
        .s_desc_limit    (in_flight.desc_limit),
        .s_desc_flags    (in_flight.desc_flags),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_selector_out  (m_selector_out),
        .m_fault         (m_fault),
        .m_error_code    (m_error_code),
        .m_status_ok     (m_status_ok),
        .m_entry_out     (m_entry_out),
        .m_tls_base_out  (m_tls_base_out),
        .m_tls_limit_out (m_tls_limit_out),
        .m_tls_flags_out (m_tls_flags_out),
        .m_fs_base_out   (m_fs_base_out),
        .m_gs_base_out   (m_gs_base_out)
    );

    req_t pending_ops[$];
    res_t expected_results[$];
    int   mismatches = 0;
    int   src_idle_pct = 11;
    int   sink_idle_pct = 70;
    bit   long_hold_req = 1'b0;

    // Predicted task state
    logic [15:0] sel_file [SEG_COUNT];
    logic [31:0] tls_base_tbl [TLS_ENTRIES];
    logic [19:0] tls_limit_tbl [TLS_ENTRIES];
    logic [6:0]  tls_flag_tbl [TLS_ENTRIES];
    logic [31:0] fs_base_q;
    logic [31:0] gs_base_q;

    function automatic void reset_task_state();
        for (int i = 0; i < SEG_COUNT; i++) sel_file[i] = '0;
        for (int i = 0; i < TLS_ENTRIES; i++) begin
            tls_base_tbl[i]  = '0;
            tls_limit_tbl[i] = '0;
            tls_flag_tbl[i]  = '0;
        end
        sel_file[SR_ES] = SEL_USER_DS;
        sel_file[SR_SS] = SEL_USER_DS;
        sel_file[SR_DS] = SEL_USER_DS;
        fs_base_q = '0;
        gs_base_q = '0;
    endfunction

    function automatic int tls_slot_of(logic [15:0] sel);
        int idx;
        idx = sel[15:3];
        if (sel[2] || idx < ENTRY_MIN || idx >= ENTRY_MIN + TLS_ENTRIES) return -1;
        return idx - ENTRY_MIN;
    endfunction

    function automatic bit can_load(logic [2:0] seg, logic [15:0] sel);
        int t;
        t = tls_slot_of(sel);
        if (sel[2]) return 1'b0;
        if (seg == SR_SS) begin
            if (sel[1:0] != 2'b11) return 1'b0;
            if (sel == SEL_USER_DS) return 1'b1;
            if (t < 0) return 1'b0;
            return tls_flag_tbl[t] != 0 && !tls_flag_tbl[t][FB_RX_ONLY];
        end
        case (int'(sel[15:3]))
            GDT_NULL, GDT_USER_CS, GDT_USER_DS, GDT_CODE64, GDT_RO_DATA: return 1'b1;
            default: ;
        endcase
        if (t < 0) return 1'b0;
        return tls_flag_tbl[t] != 0;
    endfunction

    function automatic void load_segment(logic [2:0] seg, logic [15:0] sel);
        int t;
        logic [31:0] b;
        t = tls_slot_of(sel);
        b = (t >= 0) ? tls_base_tbl[t] : 32'd0;
        sel_file[seg] = sel;
        if (seg == SR_FS) fs_base_q = b;
        else if (seg == SR_GS) gs_base_q = b;
    endfunction

    function automatic bit is_clearing(req_t r);
        return r.desc_base == 0 && r.desc_limit == 0 &&
               (r.desc_flags == 0 || r.desc_flags == F_EMPTY);
    endfunction

    // Reload a segment that holds the TLS selector just rewritten
    function automatic void reload_if_holds(logic [2:0] seg, logic [15:0] tsel);
        if (sel_file[seg] == tsel) load_segment(seg, can_load(seg, tsel) ? tsel : 16'd0);
    endfunction

    function automatic res_t execute_segment_op(req_t r);
        res_t res;
        bit ent_ok;
        int slot;
        bit ok;
        bit cs_ok;
        logic [15:0] tsel;
        logic [15:0] s;
        logic [15:0] cs;
        logic [15:0] ss;
        res = '0;
        ent_ok = r.tls_entry >= ENTRY_MIN && r.tls_entry < ENTRY_MIN + TLS_ENTRIES;
        slot = ent_ok ? int'(r.tls_entry) - ENTRY_MIN : 0;
        case (op_t'(r.operation))
            OP_READ: begin
                if (r.segment == SR_CS) res.selector_out = SEL_USER_CS;
                else if (r.segment < SEG_COUNT) res.selector_out = sel_file[r.segment];
            end
            OP_LOAD: begin
                if (r.segment < SEG_COUNT) begin
                    if (can_load(r.segment, r.selector)) begin
                        load_segment(r.segment, r.selector);
                    end else begin
                        res.fault = 1'b1;
                        res.error_code = r.selector & SEL_MASK;
                    end
                end
            end
            OP_SET_TLS: begin
                // flags[2:1] is the contents field; only contents 0 and 1 are taken
                ok = is_clearing(r) || (r.desc_flags[FB_32BIT] && !r.desc_flags[FB_CONT_HI]
                                        && !r.desc_flags[FB_NOT_PRS]);
                if (ent_ok && ok) begin
                    tsel = {9'd0, r.tls_entry, 3'b011};
                    if (is_clearing(r)) begin
                        tls_base_tbl[slot]  = '0;
                        tls_limit_tbl[slot] = '0;
                        tls_flag_tbl[slot]  = '0;
                    end else begin
                        tls_base_tbl[slot]  = r.desc_base;
                        tls_limit_tbl[slot] = r.desc_limit[19:0];
                        tls_flag_tbl[slot]  = r.desc_flags;
                    end
                    reload_if_holds(SR_ES, tsel);
                    reload_if_holds(SR_DS, tsel);
                    reload_if_holds(SR_FS, tsel);
                    reload_if_holds(SR_GS, tsel);
                    res.status_ok = 1'b1;
                end
            end
            OP_GET_TLS: begin
                if (ent_ok) begin
                    if (tls_flag_tbl[slot] == 0) begin
                        res.tls_flags_out = F_EMPTY;
                    end else begin
                        res.tls_base_out  = tls_base_tbl[slot];
                        res.tls_limit_out = tls_limit_tbl[slot];
                        res.tls_flags_out = tls_flag_tbl[slot];
                    end
                end
            end
            OP_FREE_TLS: begin
                for (int i = TLS_ENTRIES - 1; i >= 0; i--) begin
                    if (tls_flag_tbl[i] == 0) begin
                        res.status_ok = 1'b1;
                        res.entry_out = 4'(ENTRY_MIN + i);
                    end
                end
            end
            OP_EXEC: reset_task_state();
            OP_SIGNAL: begin
                sel_file[SR_ES] = SEL_USER_DS;
                sel_file[SR_SS] = SEL_USER_DS;
                sel_file[SR_DS] = SEL_USER_DS;
            end
            OP_SIGRET_DS: begin
                if (r.segment < SEG_COUNT) begin
                    s = r.selector | 16'd3;
                    if (s[15:3] == 0 || !can_load(r.segment, s)) s = '0;
                    load_segment(r.segment, s);
                end
            end
            OP_SIGRET_CS: begin
                cs = r.selector | 16'd3;
                ss = r.stack_selector | 16'd3;
                cs_ok = cs == SEL_USER_CS;
                if (cs_ok && can_load(SR_SS, ss)) begin
                    load_segment(SR_SS, ss);
                end else begin
                    res.fault = 1'b1;
                    res.error_code = ss[2] ? 16'd0 : ((cs_ok ? ss : cs) & SEL_MASK);
                end
            end
            default: ;
        endcase
        res.fs_base_out = fs_base_q;
        res.gs_base_out = gs_base_q;
        return res;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Driver: predict on each input transfer, then offer the next pending op
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(execute_segment_op(in_flight));
            if (!s_valid || s_ready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_flight <= pending_ops.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Monitor: check each result transfer and throttle m_ready
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none, got selector 0x%0h",
                             $time, m_selector_out);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("selector_out", 32'(want.selector_out),
                                  32'(m_selector_out));
                    compare_field("fault", 32'(want.fault), 32'(m_fault));
                    compare_field("error_code", 32'(want.error_code), 32'(m_error_code));
                    compare_field("status_ok", 32'(want.status_ok), 32'(m_status_ok));
                    compare_field("entry_out", 32'(want.entry_out), 32'(m_entry_out));
                    compare_field("tls_base_out", want.tls_base_out, m_tls_base_out);
                    compare_field("tls_limit_out", 32'(want.tls_limit_out),
                                  32'(m_tls_limit_out));
                    compare_field("tls_flags_out", 32'(want.tls_flags_out),
                                  32'(m_tls_flags_out));
                    compare_field("fs_base_out", want.fs_base_out, m_fs_base_out);
                    compare_field("gs_base_out", want.gs_base_out, m_gs_base_out);
                end
            end
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic push_op(input logic [3:0] op, input logic [2:0] seg,
                           input logic [15:0] sel, input logic [15:0] ssel,
                           input logic [3:0] ent, input logic [31:0] base,
                           input logic [31:0] limit, input logic [6:0] flags);
        req_t r;
        r = '{op, seg, sel, ssel, ent, base, limit, flags};
        pending_ops.push_back(r);
    endtask

    function automatic logic [15:0] pick_selector();
        logic [15:0] picks [8];
        logic [15:0] sel;
        picks = '{16'h0000, 16'h0023, 16'h002b, 16'h0033,
                  16'h007b, 16'h0063, 16'h006b, 16'h0073};
        if ($urandom_range(99) < 12) return 16'($urandom_range(65535));
        sel = picks[$urandom_range(7)];
        sel[1:0] = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b11;
        if ($urandom_range(19) == 0) sel[2] = 1'b1;
        return sel;
    endfunction

    function automatic req_t random_op();
        req_t r;
        int pick;
        pick = $urandom_range(99);
        r.operation = pick < 14 ? OP_READ : pick < 32 ? OP_LOAD : pick < 46 ? OP_SET_TLS :
                      pick < 56 ? OP_GET_TLS : pick < 62 ? OP_FREE_TLS :
                      pick < 63 ? OP_EXEC : pick < 68 ? OP_SIGNAL :
                      pick < 82 ? OP_SIGRET_DS : pick < 98 ? OP_SIGRET_CS :
                      4'($urandom_range(15, 9));
        r.segment = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                             : 3'($urandom_range(5));
        r.selector = pick_selector();
        r.stack_selector = pick_selector();
        r.tls_entry = ($urandom_range(15) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(14, 12));
        r.desc_base = $urandom();
        r.desc_limit = $urandom();
        r.desc_flags = 7'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 15) begin
            // clearing descriptor
            r.desc_base = '0;
            r.desc_limit = '0;
            r.desc_flags = $urandom_range(1) ? F_EMPTY : 7'd0;
        end else if (pick < 70) begin
            r.desc_flags[FB_32BIT] = 1'b1;
            r.desc_flags[2:1] = 2'($urandom_range(2));
            r.desc_flags[FB_NOT_PRS] = 1'b0;
        end
        if ($urandom_range(19) == 0) r.desc_base = '1;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        repeat (count) pending_ops.push_back(random_op());
    endtask

    initial begin
        reset_task_state();
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_op(OP_READ, SR_CS, '0, '0, 4'd12, '0, '0, '0);
        push_op(OP_READ, SR_SS, '1, '1, 4'd12, '1, '1, '1);
        push_op(OP_READ, 3'd7, '0, '0, 4'd12, '0, '0, '0);
        push_op(OP_LOAD, SR_DS, 16'h0004, '0, 4'd12, '0, '0, '0);
        push_op(OP_LOAD, SR_SS, 16'h0028, '0, 4'd12, '0, '0, '0);
        push_op(OP_LOAD, SR_CS, 16'h007b, '0, 4'd12, '0, '0, '0);
        push_op(OP_LOAD, SR_FS, 16'h0063, '0, 4'd12, '0, '0, '0);
        push_op(OP_SET_TLS, SR_ES, '0, '0, 4'd12, '1, '1, F_GOOD);
        push_op(OP_LOAD, SR_FS, 16'h0063, '0, 4'd12, '0, '0, '0);
        push_op(OP_LOAD, SR_SS, 16'h0063, '0, 4'd12, '0, '0, '0);
        push_op(OP_GET_TLS, SR_ES, '0, '0, 4'd12, '0, '0, '0);
        push_op(OP_GET_TLS, SR_ES, '0, '0, 4'd13, '0, '0, '0);
        push_op(OP_GET_TLS, SR_ES, '0, '0, 4'd15, '0, '0, '0);
        push_op(OP_SET_TLS, SR_ES, '0, '0, 4'd0, 32'h1234, 32'h55, 7'h01);
        push_op(OP_SET_TLS, SR_ES, '0, '0, 4'd13, 32'h1000, 32'hfff, 7'h7f);
        push_op(OP_FREE_TLS, SR_ES, '0, '0, 4'd12, '0, '0, '0);
        push_op(OP_SET_TLS, SR_ES, '0, '0, 4'd12, '0, '0, F_EMPTY);
        push_op(OP_LOAD, 3'd6, '1, '1, 4'd12, '0, '0, '0);
        push_op(OP_SIGRET_DS, SR_GS, 16'h0000, '0, 4'd12, '0, '0, '0);
        push_op(OP_SIGRET_DS, SR_ES, 16'h0030, '0, 4'd12, '0, '0, '0);
        push_op(OP_SIGRET_CS, SR_ES, 16'h0020, 16'h0028, 4'd12, '0, '0, '0);
        push_op(OP_SIGRET_CS, SR_ES, 16'h0020, 16'h0004, 4'd12, '0, '0, '0);
        push_op(OP_SIGRET_CS, SR_ES, 16'hffff, 16'h0000, 4'd12, '0, '0, '0);
        push_op(OP_SIGNAL, SR_ES, '0, '0, 4'd12, '0, '0, '0);
        push_op(OP_UNUSED, 3'd7, '1, '1, 4'd15, '1, '1, '1);
        push_op(OP_EXEC, SR_ES, '0, '0, 4'd12, '0, '0, '0);
        run_random(350);
        wait_drained();

        src_idle_pct = 70;
        sink_idle_pct = 11;
        run_random(350);
        wait_drained();

        // no idling; start with a long receiver hold so the unit backs up
        src_idle_pct = 0;
        sink_idle_pct = 0;
        run_random(350);
        long_hold_req = 1'b1;
        wait_drained();

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("** segment_register_tls_unit: PASSED **");
        end else begin
            $display("** segment_register_tls_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** segment_register_tls_unit: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/srtu_pkg.sv
design/srtu_core.sv
design/segment_register_tls_unit.sv
verif/segment_register_tls_unit_tb.sv
